@@ src/floor_ceiling_texcoord_caster_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the floor/ceiling texture coordinate caster
// Concurrent checks that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef FLOOR_CEILING_TEXCOORD_CASTER_CORE_MACROS_SVH
`define FLOOR_CEILING_TEXCOORD_CASTER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define FCC_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define FCC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FCC_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)

`define FCC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/fcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared widths, codes, command and divider types of the caster.
// ----------------------------------------------------------------------------
package fcc_pkg;

    // field widths
    localparam int ROW_W     = 10;
    localparam int COL_W     = 10;
    localparam int COORD_W   = 24;
    localparam int FRAC_W    = 16;
    localparam int MAP_W     = 8;
    localparam int WB_W      = 11;
    localparam int TEX_W     = 6;
    localparam int TEXDIM_W  = 11;
    localparam int WGT_W     = FRAC_W + 1;
    localparam int DIV_W     = 24;
    localparam int DIV_CNT_W = 5;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 48;

    // command queue depth (power of two)
    localparam int QUEUE_DEPTH = 2;

    // parameter defaults
    localparam int DEF_SCREEN_HEIGHT = 512;
    localparam int DEF_TEX_WIDTH     = 64;
    localparam int DEF_TEX_HEIGHT    = 64;

    // fixed point constants
    localparam logic [COORD_W-1:0] MASK24  = {COORD_W{1'b1}};
    localparam logic [WGT_W-1:0]   ONE_Q16 = WGT_W'(1) << FRAC_W;

    // function codes
    localparam logic FUNC_SETUP = 1'b0;
    localparam logic FUNC_ROW   = 1'b1;

    // wall side codes
    localparam logic [1:0] SIDE_X_LO = 2'd0;
    localparam logic [1:0] SIDE_X_HI = 2'd1;
    localparam logic [1:0] SIDE_Y_LO = 2'd2;

    // ray direction sign codes
    localparam logic [1:0] DIR_POS = 2'd1;
    localparam logic [1:0] DIR_NEG = 2'd2;

    // configuration register indexes
    localparam logic CFG_PLAYER_X = 1'b0;
    localparam logic CFG_PLAYER_Y = 1'b1;

    // command from the front end to the back end
    typedef struct packed {
        logic               setup;
        logic [COL_W-1:0]   column;
        logic [COORD_W-1:0] fpx;
        logic [COORD_W-1:0] fpy;
        logic [COORD_W-1:0] wall_dist;
        logic [ROW_W-1:0]   first_row;
    } cmd_t;

    // divider request
    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     rem;
        logic [DIV_W-1:0]     low;
        logic [DIV_CNT_W-1:0] steps;
        logic [DIV_W-1:0]     divisor;
    } div_req_t;

    // divider status
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_DIST_WAIT,
        ST_WGT,
        ST_WGT_WAIT,
        ST_MUL,
        ST_TEX,
        ST_FIN
    } back_state_t;

endpackage

@@ src/fcc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_front
// Accepts requests, decodes setup items into a wall floor point and first row.
// ----------------------------------------------------------------------------
module fcc_front
    import fcc_pkg::*;
#(
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
)
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // column, side, ray_x_sign, ray_y_sign, map_x, map_y, wall_frac,
    // wall_dist, wall_bottom_row (from bit 0 up)
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // func
    input  logic [0:0]           s_axis_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    localparam logic [ROW_W-1:0] SH = ROW_W'(SCREEN_HEIGHT);

    logic [COL_W-1:0]   column;
    logic [1:0]         side;
    logic [1:0]         xs;
    logic [1:0]         ys;
    logic [MAP_W-1:0]   map_x;
    logic [MAP_W-1:0]   map_y;
    logic [FRAC_W-1:0]  frac;
    logic [COORD_W-1:0] wdist;
    logic [WB_W-1:0]    wb;
    logic [COORD_W-1:0] x_plus_one;
    logic [COORD_W-1:0] y_plus_one;
    logic [WB_W-1:0]    first_full;

    // unpack the request
    assign column = s_axis_tdata[9:0];
    assign side   = s_axis_tdata[11:10];
    assign xs     = s_axis_tdata[13:12];
    assign ys     = s_axis_tdata[15:14];
    assign map_x  = s_axis_tdata[23:16];
    assign map_y  = s_axis_tdata[31:24];
    assign frac   = s_axis_tdata[47:32];
    assign wdist  = s_axis_tdata[71:48];
    assign wb     = s_axis_tdata[82:72];

    // cell + 1.0, saturating at the top cell
    assign x_plus_one = (map_x == '1) ? MASK24 : {map_x + MAP_W'(1), {FRAC_W{1'b0}}};
    assign y_plus_one = (map_y == '1) ? MASK24 : {map_y + MAP_W'(1), {FRAC_W{1'b0}}};

    assign first_full = {1'b0, wb[WB_W-2:0]} + WB_W'(1);

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    // floor point at the foot of the wall and first row
    always_comb
    begin
        q_cmd.setup     = (s_axis_tuser[0] == FUNC_SETUP);
        q_cmd.column    = column;
        q_cmd.wall_dist = wdist;
        if (side == SIDE_X_LO && xs == DIR_POS)
        begin
            q_cmd.fpx = {map_x, {FRAC_W{1'b0}}};
            q_cmd.fpy = {map_y, frac};
        end
        else if (side == SIDE_X_HI && xs == DIR_NEG)
        begin
            q_cmd.fpx = x_plus_one;
            q_cmd.fpy = {map_y, frac};
        end
        else if (side == SIDE_Y_LO && ys == DIR_POS)
        begin
            q_cmd.fpx = {map_x, frac};
            q_cmd.fpy = {map_y, {FRAC_W{1'b0}}};
        end
        else
        begin
            q_cmd.fpx = {map_x, frac};
            q_cmd.fpy = y_plus_one;
        end
        // negative bottom row or a first row off screen leaves no rows
        if (wb[WB_W-1] || first_full >= WB_W'(SH))
        begin
            q_cmd.first_row = SH;
        end
        else
        begin
            q_cmd.first_row = first_full[ROW_W-1:0];
        end
    end

endmodule

@@ src/fcc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_queue
// Small command FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module fcc_queue
    import fcc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ src/fcc_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fcc_divider
    import fcc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     rem_next;
    logic [DIV_W-1:0]     low_reg;
    logic [DIV_W-1:0]     low_next;
    logic [DIV_W-1:0]     quot_reg;
    logic [DIV_W-1:0]     quot_next;
    logic [DIV_W-1:0]     div_reg;
    logic [DIV_W-1:0]     div_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;

    // shift in one dividend bit and try a subtract
    assign trial = {rem_reg, low_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.rem;
            low_next  = req.low;
            quot_next = '0;
            div_next  = req.divisor;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            low_next = {low_reg[DIV_W-2:0], 1'b0};
            if (!diff[DIV_W])
            begin
                rem_next  = diff[DIV_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[DIV_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        div_reg  <= div_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

@@ src/fcc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_back
// Column state, row weight via the shared divider, blend and texel output.
// ----------------------------------------------------------------------------
module fcc_back
    import fcc_pkg::*;
#(
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int TEX_WIDTH     = DEF_TEX_WIDTH,
    parameter int TEX_HEIGHT    = DEF_TEX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [0:0]            cfg_index,
    input  logic [COORD_W-1:0]    cfg_data,
    input  logic                  q_not_empty,
    input  cmd_t                  q_head,
    output logic                  q_pop,
    output div_req_t              div_req,
    input  div_rsp_t              div_rsp,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [0:0]            m_axis_tuser
);

    localparam logic [ROW_W-1:0]    SH = ROW_W'(SCREEN_HEIGHT);
    localparam logic [TEXDIM_W-1:0] TW = TEXDIM_W'(TEX_WIDTH);
    localparam logic [TEXDIM_W-1:0] TH = TEXDIM_W'(TEX_HEIGHT);
    localparam int PROD_W = WGT_W + COORD_W + 2;
    localparam int TPROD_W = FRAC_W + TEXDIM_W;

    back_state_t state_reg;
    back_state_t state_next;

    logic [COORD_W-1:0]        px_reg;
    logic [COORD_W-1:0]        px_next;
    logic [COORD_W-1:0]        py_reg;
    logic [COORD_W-1:0]        py_next;
    logic [COORD_W-1:0]        fpx_reg;
    logic [COORD_W-1:0]        fpx_next;
    logic [COORD_W-1:0]        fpy_reg;
    logic [COORD_W-1:0]        fpy_next;
    logic [COORD_W-1:0]        swd_reg;
    logic [COORD_W-1:0]        swd_next;
    logic [COL_W-1:0]          col_reg;
    logic [COL_W-1:0]          col_next;
    logic [ROW_W-1:0]          row_reg;
    logic [ROW_W-1:0]          row_next;
    logic [ROW_W-1:0]          r_reg;
    logic [ROW_W-1:0]          r_next;
    logic                      fin_done_reg;
    logic                      fin_done_next;
    logic [COORD_W-1:0]        dist_reg;
    logic [COORD_W-1:0]        dist_next;
    logic [WGT_W-1:0]          w_reg;
    logic [WGT_W-1:0]          w_next;
    logic signed [PROD_W-1:0]  prodx_reg;
    logic signed [PROD_W-1:0]  prodx_next;
    logic signed [PROD_W-1:0]  prody_reg;
    logic signed [PROD_W-1:0]  prody_next;
    logic [TPROD_W-1:0]        tu_reg;
    logic [TPROD_W-1:0]        tu_next;
    logic [TPROD_W-1:0]        tv_reg;
    logic [TPROD_W-1:0]        tv_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [OUT_DATA_W-1:0]     out_data_reg;
    logic [OUT_DATA_W-1:0]     out_data_next;
    logic                      out_done_reg;
    logic                      out_done_next;

    logic [ROW_W:0]            two_r;
    logic [ROW_W:0]            two_r_head;
    logic [ROW_W:0]            d_full;
    logic [ROW_W-1:0]          d;
    logic                      dist_sat;
    logic                      wgt_sat;
    logic [WGT_W-1:0]          q17;
    logic signed [COORD_W:0]   diffx;
    logic signed [COORD_W:0]   diffy;
    logic [COORD_W-1:0]        cx;
    logic [COORD_W-1:0]        cy;
    logic [ROW_W-1:0]          ceil_row;
    logic                      out_free;

    // row geometry
    assign two_r_head = {row_reg, 1'b0};
    assign two_r      = {r_reg, 1'b0};
    assign d_full     = two_r - {1'b0, SH};
    assign d          = d_full[ROW_W-1:0];
    // distance exceeds 24 bits when H >= d * 256
    assign dist_sat   = ({8'b0, SH} >= {d, 8'b0});
    // weight quotient reaches 2.0 when dist >= 2 * wall distance
    assign wgt_sat    = ({1'b0, dist_reg} >= {swd_reg, 1'b0});
    assign q17        = div_rsp.quot[WGT_W-1:0];

    // blend: p + w * (fp - p) / 2^16
    assign diffx = $signed({1'b0, fpx_reg}) - $signed({1'b0, px_reg});
    assign diffy = $signed({1'b0, fpy_reg}) - $signed({1'b0, py_reg});
    assign cx    = px_reg + prodx_reg[FRAC_W+COORD_W-1:FRAC_W];
    assign cy    = py_reg + prody_reg[FRAC_W+COORD_W-1:FRAC_W];

    assign ceil_row = SH - r_reg;
    assign out_free = !out_valid_reg || m_axis_tready;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        fpx_next       = fpx_reg;
        fpy_next       = fpy_reg;
        swd_next       = swd_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        r_next         = r_reg;
        fin_done_next  = fin_done_reg;
        dist_next      = dist_reg;
        w_next         = w_reg;
        prodx_next     = prodx_reg;
        prody_next     = prody_reg;
        tu_next        = tu_reg;
        tv_next        = tv_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_done_next  = out_done_reg;
        q_pop          = 1'b0;
        div_req        = '0;

        // player position writes
        if (cfg_valid)
        begin
            if (cfg_index[0] == CFG_PLAYER_X)
            begin
                px_next = cfg_data;
            end
            else
            begin
                py_next = cfg_data;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop = 1'b1;
                    if (q_head.setup)
                    begin
                        fpx_next = q_head.fpx;
                        fpy_next = q_head.fpy;
                        swd_next = q_head.wall_dist;
                        col_next = q_head.column;
                        row_next = q_head.first_row;
                    end
                    else if (row_reg >= SH)
                    begin
                        fin_done_next = 1'b1;
                        state_next    = ST_FIN;
                    end
                    else
                    begin
                        fin_done_next = 1'b0;
                        r_next        = row_reg;
                        row_next      = row_reg + ROW_W'(1);
                        if (two_r_head > {1'b0, SH})
                        begin
                            state_next = ST_DIST;
                        end
                        else if (two_r_head == {1'b0, SH})
                        begin
                            w_next     = ONE_Q16;
                            state_next = ST_MUL;
                        end
                        else
                        begin
                            w_next     = '0;
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_DIST:
            begin
                if (dist_sat)
                begin
                    dist_next  = MASK24;
                    state_next = ST_WGT;
                end
                else
                begin
                    div_req.start   = 1'b1;
                    div_req.rem     = DIV_W'(SH >> 8);
                    div_req.low     = {SH[7:0], {FRAC_W{1'b0}}};
                    div_req.steps   = DIV_CNT_W'(DIV_W);
                    div_req.divisor = DIV_W'(d);
                    state_next      = ST_DIST_WAIT;
                end
            end
            ST_DIST_WAIT:
            begin
                if (div_rsp.done)
                begin
                    dist_next  = div_rsp.quot;
                    state_next = ST_WGT;
                end
            end
            ST_WGT:
            begin
                if (swd_reg == '0 || wgt_sat)
                begin
                    w_next     = ONE_Q16;
                    state_next = ST_MUL;
                end
                else
                begin
                    div_req.start   = 1'b1;
                    div_req.rem     = {1'b0, dist_reg[COORD_W-1:1]};
                    div_req.low     = {dist_reg[0], {(DIV_W-1){1'b0}}};
                    div_req.steps   = DIV_CNT_W'(WGT_W);
                    div_req.divisor = swd_reg;
                    state_next      = ST_WGT_WAIT;
                end
            end
            ST_WGT_WAIT:
            begin
                if (div_rsp.done)
                begin
                    w_next     = (q17 > ONE_Q16) ? ONE_Q16 : q17;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prodx_next = PROD_W'($signed({1'b0, w_reg}) * diffx);
                prody_next = PROD_W'($signed({1'b0, w_reg}) * diffy);
                state_next = ST_TEX;
            end
            ST_TEX:
            begin
                // integer part drops out of the texture wrap
                tu_next    = cx[FRAC_W-1:0] * TW;
                tv_next    = cy[FRAC_W-1:0] * TH;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_done_next  = fin_done_reg;
                    if (fin_done_reg)
                    begin
                        out_data_next = {7'b0, col_reg, 31'b0};
                    end
                    else
                    begin
                        out_data_next = {7'b0, col_reg, ceil_row, r_reg[8:0],
                                         tv_reg[FRAC_W+TEX_W-1:FRAC_W],
                                         tu_reg[FRAC_W+TEX_W-1:FRAC_W]};
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            px_reg        <= '0;
            py_reg        <= '0;
            col_reg       <= '0;
            row_reg       <= SH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        fpx_reg      <= fpx_next;
        fpy_reg      <= fpy_next;
        swd_reg      <= swd_next;
        r_reg        <= r_next;
        fin_done_reg <= fin_done_next;
        dist_reg     <= dist_next;
        w_reg        <= w_next;
        prodx_reg    <= prodx_next;
        prody_reg    <= prody_next;
        tu_reg       <= tu_next;
        tv_reg       <= tv_next;
        out_data_reg <= out_data_next;
        out_done_reg <= out_done_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_done_reg;

endmodule

@@ src/floor_ceiling_texcoord_caster_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floor_ceiling_texcoord_caster_core
// Floor and ceiling texture coordinates for one raycaster screen column.
// ----------------------------------------------------------------------------
// A setup request (tuser 0) is queued at its accepting edge, sets the column
// state and gives no result. A row request (tuser 1) gives one result: the
// texel (u,v) shared by the floor row and its mirrored ceiling row, or a done
// flag once the column has no rows left. A row below the screen middle runs the
// shared radix-2 divider once for the row distance (24 quotient bits) and once
// for the blend weight (17 quotient bits); either pass is skipped when it
// saturates. Rows at or above the middle skip the divider; done results go to
// ST_FIN. A two-entry command queue lets requests be taken while the back end
// works, and a registered output lets the next row start while a result waits.
// The user writes player position through the cfg port (index 0 x, index 1 y,
// Q8.16) only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "floor_ceiling_texcoord_caster_core_macros.svh"

module floor_ceiling_texcoord_caster_core
    import fcc_pkg::*;
#(
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int TEX_WIDTH     = DEF_TEX_WIDTH,
    parameter int TEX_HEIGHT    = DEF_TEX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // column[9:0], side[11:10], ray_x_sign[13:12], ray_y_sign[15:14],
    // map_x[23:16], map_y[31:24], wall_frac[47:32], wall_dist[71:48],
    // wall_bottom_row[82:72]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func[0]
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tex_u[5:0], tex_v[11:6], floor_row[20:12], ceiling_row[30:21],
    // out_column[40:31]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // done_res[0]
    output logic [0:0]            m_axis_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [COORD_W-1:0]    cfg_data
);

    localparam logic [8:0] SH9 = 9'(SCREEN_HEIGHT);

    cmd_t     push_cmd;
    cmd_t     head_cmd;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_not_empty;
    div_req_t div_req;
    div_rsp_t div_rsp;

    assign cfg_ready = 1'b1;

    fcc_front #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    fcc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_cmd)
    );

    fcc_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    fcc_back #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .TEX_WIDTH     (TEX_WIDTH),
        .TEX_HEIGHT    (TEX_HEIGHT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_not_empty   (q_not_empty),
        .q_head        (head_cmd),
        .q_pop         (q_pop),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // a done result carries only the column
    `FCC_ASSERT_IMPL(a_done_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[30:0] == 31'b0, "done result with nonzero row or texel")

    // the divider is never restarted mid-division
    `FCC_ASSERT_IMPL(a_div_start, clk, rst_n, div_req.start, !div_rsp.busy, "divider started while busy")

    // a division finishes with the divider idle
    `FCC_ASSERT_NEXT(a_div_done, clk, rst_n, div_rsp.done, !div_rsp.busy || div_req.start, "divider busy after done")

    // a command is never popped from an empty queue
    `FCC_ASSERT_IMPL(a_pop_empty, clk, rst_n, q_pop, q_not_empty, "command popped from empty queue")

    // floor rows stay on screen for small screens
    `FCC_ASSERT_IMPL(a_row_range, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0] && SCREEN_HEIGHT <= 512, m_axis_tdata[20:12] < SH9 || SCREEN_HEIGHT == 512, "floor row off screen")

endmodule
